// ===== sv/ray_box_slab_intersect_top_macros.svh =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection: assertion macros
// Concurrent assertion wrappers on clk; only RBSI_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RBSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RBSI_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBSI_ASSERT(lbl, prop, msg)
`define RBSI_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== sv/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray/box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int W       = 32;
	localparam int FRAC    = 16;
	localparam int ADDR_W  = 5;
	localparam int NUM_W   = W + 1 + FRAC;
	localparam int DIV_QW  = W + 1;
	localparam int DIV_STEP = 3;
	localparam int DIV_ST  = DIV_QW / DIV_STEP;
	localparam int DIV_LAT = DIV_ST + 1;
	localparam int ST_XY   = DIV_LAT + 1;
	localparam int ST_Z    = DIV_LAT + 2;
	localparam int ST_OUT  = DIV_LAT + 3;
	localparam int N_ST    = DIV_LAT + 4;
	localparam int T_W     = W + 2;

	typedef logic signed [T_W-1:0] tval_t;

	localparam tval_t T_NEG = -(tval_t'(1) <<< W);
	localparam tval_t T_POS = tval_t'(1) <<< W;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][W-1:0] lo;
		logic [2:0][W-1:0] hi;
	} box_cfg_t;

	typedef struct packed {
		logic [N_ST-1:0] en;
		logic [N_ST-1:0] vld;
	} pipe_ctrl_t;

endpackage

// ===== sv/ray_box_slab_intersect_top.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection, top level
// Tests Q16.16 rays against a configured axis-aligned box by the slab method.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    origin_*, dir_*, range_start/end
//   out      out  out_valid / out_ready  hit, hit_distance
//   cfg      in   APB psel/penable       box_min_*, box_max_* at 4*i
//
// One item per cycle while the output is not stalled. An item passes a prep
// stage, six parallel dividers (11 stages of 3 quotient bits plus a saturation
// stage) and three merge/result stages before out_valid.
// Empty stages keep filling while the output is stalled; a held item waits.
// Reset clears valid bits and the box to the unit cube.
// ----------------------------------------------------------------------------
`include "ray_box_slab_intersect_top_macros.svh"

module ray_box_slab_intersect_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rbsi_pkg::ADDR_W-1:0]        paddr,
	input  logic [rbsi_pkg::W-1:0]             pwdata,
	output logic [rbsi_pkg::W-1:0]             prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [rbsi_pkg::W-1:0]      origin_x,
	input  logic signed [rbsi_pkg::W-1:0]      origin_y,
	input  logic signed [rbsi_pkg::W-1:0]      origin_z,
	input  logic signed [rbsi_pkg::W-1:0]      dir_x,
	input  logic signed [rbsi_pkg::W-1:0]      dir_y,
	input  logic signed [rbsi_pkg::W-1:0]      dir_z,
	input  logic signed [rbsi_pkg::W-1:0]      range_start,
	input  logic signed [rbsi_pkg::W-1:0]      range_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic signed [rbsi_pkg::W-1:0]      hit_distance
);

	localparam int W  = rbsi_pkg::W;
	localparam int DL = rbsi_pkg::DIV_LAT;

	typedef struct packed {
		logic [2:0]          zero;
		logic [2:0]          outside;
		logic signed [W-1:0] r0;
		logic signed [W-1:0] r1;
	} side_t;

	rbsi_pkg::box_cfg_t   box;
	rbsi_pkg::pipe_ctrl_t ctl;

	rbsi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.box     (box)
	);

	rbsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// prep: slab corner differences, magnitudes and signs
	logic signed [W-1:0] ax_o [3];
	logic signed [W-1:0] ax_d [3];
	logic [rbsi_pkg::NUM_W-1:0] num_c [6];
	logic [W-1:0] den_c [3];
	logic [5:0] neg_c;
	logic [2:0] zero_c, out_c;

	assign ax_o[0] = origin_x;
	assign ax_o[1] = origin_y;
	assign ax_o[2] = origin_z;
	assign ax_d[0] = dir_x;
	assign ax_d[1] = dir_y;
	assign ax_d[2] = dir_z;

	for (genvar a = 0; a < 3; a++) begin : g_prep
		logic signed [W-1:0] lo, hi, c_en, c_lv;
		logic signed [W:0]   df_en, df_lv;
		logic [W:0]          mg_en, mg_lv;
		logic                dneg;

		assign lo    = $signed(box.lo[a]);
		assign hi    = $signed(box.hi[a]);
		assign dneg  = ax_d[a][W-1];
		assign c_en  = dneg ? hi : lo;
		assign c_lv  = dneg ? lo : hi;
		assign df_en = (W+1)'(c_en) - (W+1)'(ax_o[a]);
		assign df_lv = (W+1)'(c_lv) - (W+1)'(ax_o[a]);
		assign mg_en = df_en[W] ? (W+1)'(-df_en) : df_en;
		assign mg_lv = df_lv[W] ? (W+1)'(-df_lv) : df_lv;

		assign num_c[2*a]   = {mg_en, {rbsi_pkg::FRAC{1'b0}}};
		assign num_c[2*a+1] = {mg_lv, {rbsi_pkg::FRAC{1'b0}}};
		assign neg_c[2*a]   = df_en[W] ^ dneg;
		assign neg_c[2*a+1] = df_lv[W] ^ dneg;
		assign den_c[a]     = dneg ? W'(-ax_d[a]) : ax_d[a];
		assign zero_c[a]    = (ax_d[a] == '0);
		assign out_c[a]     = (ax_o[a] < lo) || (ax_o[a] > hi);
	end

	logic [rbsi_pkg::NUM_W-1:0] num_s0 [6];
	logic [W-1:0]               den_s0 [3];
	logic [5:0]                 neg_s0;
	side_t                      side_s [DL+1];

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			for (int i = 0; i < 6; i++) begin
				num_s0[i] <= num_c[i];
			end
			for (int i = 0; i < 3; i++) begin
				den_s0[i] <= den_c[i];
			end
			neg_s0            <= neg_c;
			side_s[0].zero    <= zero_c;
			side_s[0].outside <= out_c;
			side_s[0].r0      <= range_start;
			side_s[0].r1      <= range_end;
		end
	end

	for (genvar k = 1; k <= DL; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (ctl.en[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// dividers: entry and exit distance per axis
	logic signed [W-1:0] q_en [3];
	logic signed [W-1:0] q_lv [3];

	for (genvar a = 0; a < 3; a++) begin : g_div
		rbsi_div u_div_en (
			.clk (clk),
			.en  (ctl.en[DL:1]),
			.num (num_s0[2*a]),
			.den (den_s0[a]),
			.neg (neg_s0[2*a]),
			.quo (q_en[a])
		);
		rbsi_div u_div_lv (
			.clk (clk),
			.en  (ctl.en[DL:1]),
			.num (num_s0[2*a+1]),
			.den (den_s0[a]),
			.neg (neg_s0[2*a+1]),
			.quo (q_lv[a])
		);
	end

	function automatic rbsi_pkg::tval_t to_t(logic signed [W-1:0] q, logic z, logic enter);
		if (z) begin
			return enter ? rbsi_pkg::T_NEG : rbsi_pkg::T_POS;
		end
		return rbsi_pkg::tval_t'(q);
	endfunction

	// x/y interval merge
	rbsi_pkg::tval_t ex, lx, ey, ly, tmin_s13, tmax_s13, ez_s13, lz_s13;
	logic miss_s13;
	logic signed [W-1:0] r0_s13, r1_s13;
	side_t sd;

	assign sd = side_s[DL];
	assign ex = to_t(q_en[0], sd.zero[0], 1'b1);
	assign lx = to_t(q_lv[0], sd.zero[0], 1'b0);
	assign ey = to_t(q_en[1], sd.zero[1], 1'b1);
	assign ly = to_t(q_lv[1], sd.zero[1], 1'b0);

	always_ff @(posedge clk) begin
		if (ctl.en[rbsi_pkg::ST_XY]) begin
			miss_s13 <= |(sd.zero & sd.outside) || (ex > ly) || (ey > lx);
			tmin_s13 <= (ey > ex) ? ey : ex;
			tmax_s13 <= (ly < lx) ? ly : lx;
			ez_s13   <= to_t(q_en[2], sd.zero[2], 1'b1);
			lz_s13   <= to_t(q_lv[2], sd.zero[2], 1'b0);
			r0_s13   <= sd.r0;
			r1_s13   <= sd.r1;
		end
	end

	// z interval merge
	rbsi_pkg::tval_t tmin_s14, tmax_s14;
	logic miss_s14;
	logic signed [W-1:0] r0_s14, r1_s14;

	always_ff @(posedge clk) begin
		if (ctl.en[rbsi_pkg::ST_Z]) begin
			miss_s14 <= miss_s13 || (tmin_s13 > lz_s13) || (ez_s13 > tmax_s13);
			tmin_s14 <= (ez_s13 > tmin_s13) ? ez_s13 : tmin_s13;
			tmax_s14 <= (lz_s13 < tmax_s13) ? lz_s13 : tmax_s13;
			r0_s14   <= r0_s13;
			r1_s14   <= r1_s13;
		end
	end

	// range test and result
	logic hit_c, hit_s15;
	logic signed [W-1:0] dist_c, dist_s15;

	assign hit_c = !miss_s14 && (tmin_s14 < rbsi_pkg::tval_t'(r1_s14))
		&& (tmax_s14 > rbsi_pkg::tval_t'(r0_s14));

	always_comb begin
		if (!hit_c) begin
			dist_c = '0;
		end else if (tmin_s14 < rbsi_pkg::tval_t'($signed({1'b1, {(W-1){1'b0}}}))) begin
			dist_c = {1'b1, {(W-1){1'b0}}};
		end else if (tmin_s14 > rbsi_pkg::tval_t'({1'b0, {(W-1){1'b1}}})) begin
			dist_c = {1'b0, {(W-1){1'b1}}};
		end else begin
			dist_c = tmin_s14[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[rbsi_pkg::ST_OUT]) begin
			hit_s15  <= hit_c;
			dist_s15 <= dist_c;
		end
	end

	assign out_valid    = ctl.vld[rbsi_pkg::N_ST-1];
	assign hit          = hit_s15;
	assign hit_distance = dist_s15;

	`RBSI_ASSERT(a_miss_zero, out_valid && !hit |-> hit_distance == '0, "miss with nonzero distance")
	`RBSI_ASSERT(a_stall_src, !in_ready |-> out_valid && !out_ready, "input stalled with room in pipe")
	`RBSI_ASSERT(a_occ_up, in_valid && in_ready && !(out_valid && out_ready) |=> $countones(ctl.vld) == $past($countones(ctl.vld)) + 1, "item lost in pipe")
	`RBSI_ASSERT_NR(a_rst_empty, !arst_n |-> ctl.vld == '0, "valid bits set in reset")

endmodule

// ===== sv/rbsi_cfg.sv =====
// ----------------------------------------------------------------------------
// rbsi_cfg
// APB register file holding the box corners.
// ----------------------------------------------------------------------------
module rbsi_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rbsi_pkg::ADDR_W-1:0]  paddr,
	input  logic [rbsi_pkg::W-1:0]       pwdata,
	output logic [rbsi_pkg::W-1:0]       prdata,
	output logic                         pready,
	output rbsi_pkg::box_cfg_t           box
);

	rbsi_pkg::box_cfg_t box_q;
	logic [2:0] idx;
	logic wr;

	assign idx    = paddr[rbsi_pkg::ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign box    = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.lo <= '0;
			for (int i = 0; i < 3; i++) begin
				box_q.hi[i] <= rbsi_pkg::W'(1) << rbsi_pkg::FRAC;
			end
		end else if (wr) begin
			unique case (idx)
				rbsi_pkg::REG_MIN_X: box_q.lo[0] <= pwdata;
				rbsi_pkg::REG_MIN_Y: box_q.lo[1] <= pwdata;
				rbsi_pkg::REG_MIN_Z: box_q.lo[2] <= pwdata;
				rbsi_pkg::REG_MAX_X: box_q.hi[0] <= pwdata;
				rbsi_pkg::REG_MAX_Y: box_q.hi[1] <= pwdata;
				rbsi_pkg::REG_MAX_Z: box_q.hi[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			rbsi_pkg::REG_MIN_X: prdata = box_q.lo[0];
			rbsi_pkg::REG_MIN_Y: prdata = box_q.lo[1];
			rbsi_pkg::REG_MIN_Z: prdata = box_q.lo[2];
			rbsi_pkg::REG_MAX_X: prdata = box_q.hi[0];
			rbsi_pkg::REG_MAX_Y: prdata = box_q.hi[1];
			rbsi_pkg::REG_MAX_Z: prdata = box_q.hi[2];
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== sv/rbsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbsi_ctrl
// Valid bits and per-stage load enables; empty stages fill under a stall.
// ----------------------------------------------------------------------------
module rbsi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	output rbsi_pkg::pipe_ctrl_t ctl
);

	localparam int N = rbsi_pkg::N_ST;

	logic [N-1:0] vld_q;
	logic [N-1:0] rdy;

	always_comb begin
		rdy[N-1] = ~vld_q[N-1] | out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			rdy[k] = ~vld_q[k] | rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = rdy[0];
	assign ctl.en   = rdy;
	assign ctl.vld  = vld_q;

endmodule

// ===== sv/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, unsigned magnitudes, signed saturated result.
// ----------------------------------------------------------------------------
module rbsi_div (
	input  logic                              clk,
	input  logic [rbsi_pkg::DIV_LAT-1:0]      en,
	input  logic [rbsi_pkg::NUM_W-1:0]        num,
	input  logic [rbsi_pkg::W-1:0]            den,
	input  logic                              neg,
	output logic signed [rbsi_pkg::W-1:0]     quo
);

	localparam int W  = rbsi_pkg::W;
	localparam int QW = rbsi_pkg::DIV_QW;
	localparam int NS = rbsi_pkg::DIV_ST;

	typedef struct packed {
		logic [W-1:0]  rem;
		logic [QW-1:0] q;
		logic [QW-1:0] nlo;
		logic [W-1:0]  den;
		logic          neg;
		logic          ovf;
	} dstage_t;

	dstage_t st_s [NS];
	dstage_t init;
	logic signed [W-1:0] quo_s;

	always_comb begin
		init.rem = W'(num[rbsi_pkg::NUM_W-1:QW]);
		init.q   = '0;
		init.nlo = num[QW-1:0];
		init.den = den;
		init.neg = neg;
		init.ovf = W'(num[rbsi_pkg::NUM_W-1:QW]) >= den;
	end

	for (genvar j = 0; j < NS; j++) begin : g_st
		dstage_t cur, nx;
		if (j == 0) begin : g_first
			assign cur = init;
		end else begin : g_next
			assign cur = st_s[j-1];
		end

		always_comb begin
			logic [W:0] t;
			nx = cur;
			for (int b = 0; b < rbsi_pkg::DIV_STEP; b++) begin
				t = {nx.rem, nx.nlo[QW-1]};
				nx.nlo = nx.nlo << 1;
				if (t >= {1'b0, nx.den}) begin
					t = t - {1'b0, nx.den};
					nx.q = {nx.q[QW-2:0], 1'b1};
				end else begin
					nx.q = {nx.q[QW-2:0], 1'b0};
				end
				nx.rem = t[W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				st_s[j] <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (st_s[NS-1].neg) begin
				if (st_s[NS-1].ovf || st_s[NS-1].q > (QW'(1) << (W - 1))) begin
					quo_s <= {1'b1, {(W-1){1'b0}}};
				end else begin
					quo_s <= -st_s[NS-1].q[W-1:0];
				end
			end else begin
				if (st_s[NS-1].ovf || st_s[NS-1].q > QW'({1'b0, {(W-1){1'b1}}})) begin
					quo_s <= {1'b0, {(W-1){1'b1}}};
				end else begin
					quo_s <= st_s[NS-1].q[W-1:0];
				end
			end
		end
	end

	assign quo = quo_s;

endmodule

// ===== tb/tb_ray_box_slab_intersect_top.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection testbench
// Drives rays through the valid/ready input channel and checks every result
// against a fixed-point slab predictor. The box corners are set over the APB
// port between phases. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect_top;

	localparam int W = rbsi_pkg::W;
	localparam int ADDR_W = rbsi_pkg::ADDR_W;
	localparam longint NEG_INF = -(64'sd1 <<< 40);
	localparam longint POS_INF = 64'sd1 <<< 40;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [W-1:0] pwdata = '0;
	logic [W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [W-1:0] range_start = '0, range_end = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [W-1:0] hit_distance;

	typedef struct {
		logic                hit;
		logic signed [W-1:0] dst;
	} hit_rec_t;

	typedef struct {
		logic signed [W-1:0] o [3];
		logic signed [W-1:0] d [3];
		logic signed [W-1:0] r0, r1;
	} ray_t;

	hit_rec_t expected_hits[$];
	longint box_lo [3];
	longint box_hi [3];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int rays_sent = 0;
	int hits_seen = 0;
	longint cycle_count = 0;

	ray_box_slab_intersect_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_ray_box_slab_intersect_top: errors");
			$finish;
		end
	end

	function automatic longint slab_quot(longint diff, longint d);
		longint q;
		q = (diff * 65536) / d;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q;
	endfunction

	function automatic hit_rec_t predict_hit(ray_t r);
		hit_rec_t res;
		longint tn, tf, a, b, o, d;
		res.hit = 1'b0;
		res.dst = '0;
		tn = NEG_INF;
		tf = POS_INF;
		for (int ax = 0; ax < 3; ax++) begin
			o = r.o[ax];
			d = r.d[ax];
			if (d == 0) begin
				if (o < box_lo[ax] || o > box_hi[ax]) return res;
				a = NEG_INF;
				b = POS_INF;
			end else if (d > 0) begin
				a = slab_quot(box_lo[ax] - o, d);
				b = slab_quot(box_hi[ax] - o, d);
			end else begin
				a = slab_quot(box_hi[ax] - o, d);
				b = slab_quot(box_lo[ax] - o, d);
			end
			if (ax > 0 && (tn > b || a > tf)) return res;
			if (ax == 0 || a > tn) tn = a;
			if (ax == 0 || b < tf) tf = b;
		end
		if (tn < longint'(r.r1) && tf > longint'(r.r0)) begin
			if (tn < -64'sd2147483648) tn = -64'sd2147483648;
			res.hit = 1'b1;
			res.dst = tn[W-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	always @(posedge clk) begin
		hit_rec_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected item", hit, 0);
				end else begin
					e = expected_hits.pop_front();
					if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
					if (hit_distance !== e.dst)
						report_mismatch("hit_distance", hit_distance, e.dst);
					if (e.hit) hits_seen++;
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_box(rbsi_pkg::reg_idx_t idx, logic signed [W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx <= rbsi_pkg::REG_MIN_Z) box_lo[int'(idx)] = val;
		else box_hi[int'(idx) - 3] = val;
	endtask

	task automatic set_box(logic signed [W-1:0] lo [3], logic signed [W-1:0] hi [3]);
		write_box(rbsi_pkg::REG_MIN_X, lo[0]);
		write_box(rbsi_pkg::REG_MIN_Y, lo[1]);
		write_box(rbsi_pkg::REG_MIN_Z, lo[2]);
		write_box(rbsi_pkg::REG_MAX_X, hi[0]);
		write_box(rbsi_pkg::REG_MAX_Y, hi[1]);
		write_box(rbsi_pkg::REG_MAX_Z, hi[2]);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_ray(ray_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		origin_x <= r.o[0]; origin_y <= r.o[1]; origin_z <= r.o[2];
		dir_x <= r.d[0]; dir_y <= r.d[1]; dir_z <= r.d[2];
		range_start <= r.r0;
		range_end <= r.r1;
		expected_hits.push_back(predict_hit(r));
		rays_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_hits.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_coord(int scale);
		case ($urandom_range(9))
			0: return $urandom;
			1: return {1'b0, {(W-1){1'b1}}};
			2: return {1'b1, {(W-1){1'b0}}};
			3: return '0;
			default: return $signed($urandom_range(2 * scale)) - scale;
		endcase
	endfunction

	function automatic ray_t rand_ray(int scale);
		ray_t r;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = rand_coord(scale);
			r.d[i] = ($urandom_range(7) == 0) ? '0 : rand_coord(scale);
		end
		if ($urandom_range(3) == 0) begin
			r.r0 = $urandom;
			r.r1 = $urandom;
		end else begin
			r.r0 = -$signed($urandom_range(65536));
			r.r1 = $urandom_range(32'h7fffffff);
		end
		return r;
	endfunction

	function automatic ray_t aimed_ray();
		ray_t r;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = box_lo[i] - 65536 + $signed($urandom_range(32768));
			r.d[i] = $urandom_range(131072) - 16384;
			if ($urandom_range(1)) begin
				r.o[i] = box_hi[i] + $urandom_range(65536);
				r.d[i] = -r.d[i];
			end
		end
		r.r0 = 0;
		r.r1 = 32'h7fffffff;
		return r;
	endfunction

	function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
		int r0, int r1);
		ray_t r;
		r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
		r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
		r.r0 = r0; r.r1 = r1;
		return r;
	endfunction

	task automatic test_directed();
		int one;
		int mx;
		int mn;
		one = 65536;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_ray(mk_ray(-one, one / 2, one / 2, one, 0, 0, 0, mx));
		send_ray(mk_ray(2 * one, one / 2, one / 2, -one, 0, 0, 0, mx));
		send_ray(mk_ray(one / 2, one / 2, one / 2, 0, 0, 0, 0, mx));
		send_ray(mk_ray(one / 2, one / 2, 2 * one, 0, 0, 0, 0, mx));
		send_ray(mk_ray(0, one, 0, 0, 0, 0, mn, mx));
		send_ray(mk_ray(one + 1, 0, 0, 0, 0, 0, mn, mx));
		send_ray(mk_ray(-one, -one, -one, one, one, one, 0, mx));
		send_ray(mk_ray(-one, -one, -one, 1, 1, 1, 0, mx));
		send_ray(mk_ray(mn, mn, mn, 1, 1, 1, mn, mx));
		send_ray(mk_ray(mx, mx, mx, mn, mn, mn, mn, mx));
		send_ray(mk_ray(mx, 0, 0, -1, 0, 0, mn, mx));
		send_ray(mk_ray(-one, -one, 0, one, 2 * one, 0, 0, mx));
		send_ray(mk_ray(-one, one / 2, one / 2, one, 0, 0, 0, one));
		send_ray(mk_ray(-one, one / 2, one / 2, one, 0, 0, 2 * one, mx));
		send_ray(mk_ray(-one, one / 2, one / 2, one, 0, 0, mx, mn));
		send_ray(mk_ray(-one, one / 2, one / 2, mx, mx, mx, mn, mx));
		send_ray(mk_ray(-1, -1, -1, -1, -1, -1, mn, mx));
		drain();
	endtask

	task automatic test_random(int count, int scale, int aimed_pct);
		for (int i = 0; i < count; i++)
			send_ray(($urandom_range(99) < aimed_pct) ? aimed_ray() : rand_ray(scale));
		drain();
	endtask

	task automatic test_box(int lx, int ly, int lz, int hx, int hy, int hz,
		int count, int scale);
		logic signed [W-1:0] lo [3];
		logic signed [W-1:0] hi [3];
		lo[0] = lx; lo[1] = ly; lo[2] = lz;
		hi[0] = hx; hi[1] = hy; hi[2] = hz;
		set_box(lo, hi);
		test_random(count, scale, 60);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		box_lo = '{0, 0, 0};
		box_hi = '{65536, 65536, 65536};
		test_directed();
		test_random(250, 4 * 65536, 60);
		send_idle_pct = 55;
		test_box(-3 * 65536, -65536, 0, 2 * 65536, 65536, 5 * 65536, 250, 8 * 65536);
		send_idle_pct = 0;
		stall_pct = 55;
		test_box(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 250, 32'h40000000);
		send_idle_pct = 35;
		stall_pct = 35;
		test_box(65536, 65536, 65536, -65536, -65536, -65536, 150, 4 * 65536);
		test_box(100, -200, 300, 100, -200, 300, 150, 4096);
		send_idle_pct = 0;
		stall_pct = 0;
		test_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 150,
			32'h40000000);
		test_box(0, 0, 0, 65536, 65536, 65536, 150, 4 * 65536);
		$display("rays sent %0d, hits %0d, over seven box settings and four idle mixes",
			rays_sent, hits_seen);
		if (error_count == 0 && expected_hits.size() == 0) begin
			$display("tb_ray_box_slab_intersect_top: clean");
		end else begin
			$display("tb_ray_box_slab_intersect_top: errors");
		end
		$finish;
	end
endmodule
